>>> design/hzs_pkg.sv
package hzs_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int TBL_FRAC            = 32;
    localparam int GUARD_TOP           = 60;
    localparam int ENERGY_BITS         = 24;
    localparam int DP_W                = 64;
    localparam int ACC_W               = 36;
    localparam int SQRT_STEPS          = 32;

    localparam longint PI_T   = 64'sd13493037705;
    localparam longint PIO2_T = 64'sd6746518852;

    typedef struct packed {
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ACC_W-1:0] a;
    } t_cvec;

    typedef struct packed {
        logic [DP_W-1:0] n;
        logic [DP_W-1:0] res;
    } t_sqrt;

    // arctan(2^-i) in units of 2^-32 rad
    function automatic logic signed [ACC_W-1:0] atan_t(input int i);
        logic signed [ACC_W-1:0] v;
        begin
            unique case (i)
                0:  v = 36'sd3373259426;
                1:  v = 36'sd1991351318;
                2:  v = 36'sd1052175346;
                3:  v = 36'sd534100635;
                4:  v = 36'sd268086748;
                5:  v = 36'sd134174063;
                6:  v = 36'sd67103403;
                7:  v = 36'sd33553749;
                8:  v = 36'sd16777131;
                9:  v = 36'sd8388597;
                10: v = 36'sd4194303;
                default: v = ACC_W'(64'sd1 <<< (32 - i + 10)) >>> 10;
            endcase
            return v;
        end
    endfunction

    // bring a vector with negative x into the right half plane
    function automatic t_cvec prerot(input logic signed [DP_W-1:0] x,
                                     input logic signed [DP_W-1:0] y);
        t_cvec v;
        begin
            v.x = x;
            v.y = y;
            v.a = '0;
            if (x < 0) begin
                if (y >= 0) begin
                    v.x = y;
                    v.y = -x;
                    v.a = ACC_W'(PIO2_T);
                end else begin
                    v.x = -y;
                    v.y = x;
                    v.a = -ACC_W'(PIO2_T);
                end
            end
            return v;
        end
    endfunction

endpackage

>>> design/hzs_sqrt_cell.sv
module hzs_sqrt_cell #(
    parameter int BITPOS = 62
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  hzs_pkg::t_sqrt i_d,
    output hzs_pkg::t_sqrt o_d
);
    localparam logic [hzs_pkg::DP_W-1:0] Bit = hzs_pkg::DP_W'(1) << BITPOS;

    logic [hzs_pkg::DP_W-1:0] w_trial;
    hzs_pkg::t_sqrt           n_d;
    hzs_pkg::t_sqrt           r_d;

    assign w_trial = i_d.res + Bit;

    always_comb begin
        if (i_d.n >= w_trial) begin
            n_d.n   = i_d.n - w_trial;
            n_d.res = (i_d.res >> 1) + Bit;
        end else begin
            n_d.n   = i_d.n;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> design/hzs_cordic_cell.sv
module hzs_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  hzs_pkg::t_cvec i_v,
    output hzs_pkg::t_cvec o_v
);
    localparam logic signed [hzs_pkg::ACC_W-1:0] Angle = hzs_pkg::atan_t(IDX);

    logic signed [hzs_pkg::DP_W-1:0] w_xs;
    logic signed [hzs_pkg::DP_W-1:0] w_ys;
    hzs_pkg::t_cvec                  n_v;
    hzs_pkg::t_cvec                  r_v;

    assign w_xs = i_v.x >>> IDX;
    assign w_ys = i_v.y >>> IDX;

    // rotate towards y = 0
    always_comb begin
        if (i_v.y < 0) begin
            n_v.x = i_v.x - w_ys;
            n_v.y = i_v.y + w_xs;
            n_v.a = i_v.a - Angle;
        end else begin
            n_v.x = i_v.x + w_ys;
            n_v.y = i_v.y - w_xs;
            n_v.a = i_v.a + Angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;
endmodule

>>> design/hit_zero_suppress_to_spherical_unit.sv
// Zero suppression of calorimeter hits with conversion to spherical angles. One hit word
// is taken every clock cycle unless the result side stalls; each gives exactly one result
// word, through one input register with the squaring multipliers, a 32-cell square-root
// chain for the transverse radius, one pre-rotation register, CORDIC_STAGES vectoring
// CORDIC cells (polar and azimuth side by side) and the output register. The whole chain
// advances together, so a stall on the result side holds every stage. Hits with energy
// not above zero come out with kept (tuser) clear and all other fields zero except tlast.
// Angles are radians with ANGLE_FRAC_BITS fraction bits; polar angle is pi/2 for z zero,
// azimuth is 0 or pi for x zero.
module hit_zero_suppress_to_spherical_unit #(
    parameter int COORD_BITS      = hzs_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = hzs_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = hzs_pkg::CORDIC_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // pos_x, pos_y, pos_z, energy
    input  logic [((3*COORD_BITS+hzs_pkg::ENERGY_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic i_s_tlast,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // out_x, out_y, out_z, out_energy, polar_angle, azimuth
    output logic [((3*COORD_BITS+23+2*ANGLE_FRAC_BITS+5+7)/8)*8-1:0] o_m_tdata,
    // kept
    output logic o_m_tuser,
    output logic o_m_tlast
);
    localparam int C    = COORD_BITS;
    localparam int DW   = hzs_pkg::DP_W;
    localparam int AW   = hzs_pkg::ACC_W;
    localparam int RHO  = (2*C < 61) ? ((61 - 2*C) / 2) : 0;
    localparam int G    = hzs_pkg::GUARD_TOP - C;
    localparam int G2   = G - RHO;
    localparam int SH   = hzs_pkg::TBL_FRAC - ANGLE_FRAC_BITS;
    localparam int PW   = ANGLE_FRAC_BITS + 2;
    localparam int ZW   = ANGLE_FRAC_BITS + 3;
    localparam int OW   = ((3*C+23+PW+ZW+7)/8)*8;
    localparam int NS   = hzs_pkg::SQRT_STEPS;
    localparam int PRE  = NS + 1;
    localparam int NSTG = PRE + CORDIC_STAGES + 2;
    localparam longint PI_Q   = (hzs_pkg::PI_T + (64'sd1 <<< (SH-1))) >>> SH;
    localparam longint PIO2_Q = (hzs_pkg::PIO2_T + (64'sd1 <<< (SH-1))) >>> SH;

    logic w_en;
    logic signed [C-1:0]  w_x, w_y, w_z;
    logic signed [2*C-1:0] w_x2, w_y2;
    logic signed [hzs_pkg::ENERGY_BITS-1:0] w_e;

    logic             r_vld  [NSTG];
    logic             r_kept [NSTG];
    logic             r_eoe  [NSTG];
    logic [C-1:0]     r_x    [NSTG];
    logic [C-1:0]     r_y    [NSTG];
    logic [C-1:0]     r_z    [NSTG];
    logic [22:0]      r_e    [NSTG];

    logic [2*C-1:0]   r_sqx, r_sqy;
    logic [2*C:0]     w_sum;
    hzs_pkg::t_sqrt   w_sq [NS+1];
    hzs_pkg::t_cvec   w_th [CORDIC_STAGES+1];
    hzs_pkg::t_cvec   w_ph [CORDIC_STAGES+1];
    hzs_pkg::t_cvec   r_th_pre, r_ph_pre;

    logic signed [DW-1:0] w_zs, w_rs, w_xs, w_ys;
    logic signed [AW-1:0] w_tr, w_pr;
    logic [PW-1:0]        n_pol, r_pol;
    logic [ZW-1:0]        n_azi, r_azi;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    assign w_x = i_s_tdata[C-1:0];
    assign w_y = i_s_tdata[2*C-1:C];
    assign w_z = i_s_tdata[3*C-1:2*C];
    assign w_e = i_s_tdata[3*C+hzs_pkg::ENERGY_BITS-1:3*C];

    assign w_x2 = {{C{w_x[C-1]}}, w_x};
    assign w_y2 = {{C{w_y[C-1]}}, w_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // sideband shift line, alongside the arithmetic cells
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kept[0] <= (w_e > 0);
            r_eoe[0]  <= i_s_tlast;
            r_x[0]    <= w_x;
            r_y[0]    <= w_y;
            r_z[0]    <= w_z;
            r_e[0]    <= w_e[22:0];
            r_sqx     <= w_x2 * w_x2;
            r_sqy     <= w_y2 * w_y2;
            for (int k = 1; k < NSTG; k++) begin
                r_kept[k] <= r_kept[k-1];
                r_eoe[k]  <= r_eoe[k-1];
                r_x[k]    <= r_x[k-1];
                r_y[k]    <= r_y[k-1];
                r_z[k]    <= r_z[k-1];
                r_e[k]    <= r_e[k-1];
            end
        end
    end

    assign w_sum     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_sq[0].n = DW'(w_sum) << (2*RHO);
    assign w_sq[0].res = '0;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        hzs_sqrt_cell #(.BITPOS(2*(NS-1-k))) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[k]),
            .o_d   (w_sq[k+1])
        );
    end

    assign w_zs = $signed({{(DW-C){r_z[NS][C-1]}}, r_z[NS]}) <<< G;
    assign w_xs = $signed({{(DW-C){r_x[NS][C-1]}}, r_x[NS]}) <<< G;
    assign w_ys = $signed({{(DW-C){r_y[NS][C-1]}}, r_y[NS]}) <<< G;
    assign w_rs = $signed(w_sq[NS].res) <<< G2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th_pre <= hzs_pkg::prerot(w_zs, w_rs);
            r_ph_pre <= hzs_pkg::prerot(w_xs, w_ys);
        end
    end

    assign w_th[0] = r_th_pre;
    assign w_ph[0] = r_ph_pre;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        hzs_cordic_cell #(.IDX(i)) u_th (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (w_th[i]),
            .o_v   (w_th[i+1])
        );
        hzs_cordic_cell #(.IDX(i)) u_ph (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (w_ph[i]),
            .o_v   (w_ph[i+1])
        );
    end

    // round to output precision, then apply the special cases and clamp
    assign w_tr = (w_th[CORDIC_STAGES].a + AW'(64'sd1 <<< (SH-1))) >>> SH;
    assign w_pr = (w_ph[CORDIC_STAGES].a + AW'(64'sd1 <<< (SH-1))) >>> SH;

    always_comb begin
        if (r_z[NSTG-2] == '0) begin
            n_pol = PW'(PIO2_Q);
        end else if (w_tr < 0) begin
            n_pol = '0;
        end else if (w_tr > AW'(PI_Q)) begin
            n_pol = PW'(PI_Q);
        end else begin
            n_pol = w_tr[PW-1:0];
        end
        if (r_x[NSTG-2] == '0) begin
            n_azi = r_y[NSTG-2][C-1] ? ZW'(PI_Q) : '0;
        end else if (w_pr > AW'(PI_Q)) begin
            n_azi = ZW'(PI_Q);
        end else if (w_pr < -AW'(PI_Q)) begin
            n_azi = ZW'(-PI_Q);
        end else begin
            n_azi = w_pr[ZW-1:0];
        end
        if (!r_kept[NSTG-2]) begin
            n_pol = '0;
            n_azi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pol <= n_pol;
            r_azi <= n_azi;
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tuser  = r_kept[NSTG-1];
    assign o_m_tlast  = r_eoe[NSTG-1];
    assign o_m_tdata  = OW'({r_azi, r_pol,
                            (r_kept[NSTG-1] ? r_e[NSTG-1] : 23'd0),
                            (r_kept[NSTG-1] ? r_z[NSTG-1] : C'(0)),
                            (r_kept[NSTG-1] ? r_y[NSTG-1] : C'(0)),
                            (r_kept[NSTG-1] ? r_x[NSTG-1] : C'(0))});

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("suppressed hit carries data");
    a_pol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pol <= PW'(PI_Q))
        else $error("polar angle out of range");
`endif
endmodule
